@@ rtl/lsdc_pkg.sv @@
// shared types, constants and tables for the linear sieve divisor count engine
package lsdc_pkg;

    localparam int TABLE_SIZE  = 65536;
    localparam int PRIME_SLOTS = 8192;

    localparam int TABLE_AW = $clog2(TABLE_SIZE);
    localparam int TABLE_MAX = TABLE_SIZE - 1;
    localparam int PL_AW    = $clog2(PRIME_SLOTS);
    localparam int CNT_W    = PL_AW + 1;
    localparam int LP_W     = CNT_W;

    localparam int VAL_W  = 16;
    localparam int ITER_W = VAL_W + 1;
    localparam int DC_W   = 8;
    localparam int EXP_W  = 4;
    localparam int PT_W   = 14;
    localparam int ST_W   = 2;

    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_SHIFT = 16;

    localparam logic [DC_W-1:0]  DC_MAX  = 8'd255;
    localparam logic [EXP_W-1:0] EXP_MAX = 4'd15;
    localparam logic [PT_W-1:0]  PT_MAX  = 14'd16383;

    localparam logic [DC_W-1:0]  DC_ONE    = 8'd1;
    localparam logic [DC_W-1:0]  DC_PRIME  = 8'd2;
    localparam logic [EXP_W-1:0] EXP_PRIME = 4'd1;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_UNBUILT = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    // ceil(2^16 / (e + 1)) for e = 0..15
    localparam logic [MUL_W-1:0] RECIP [16] = '{
        17'd65536, 17'd32768, 17'd21846, 17'd16384,
        17'd13108, 17'd10923, 17'd9363,  17'd8192,
        17'd7282,  17'd6554,  17'd5958,  17'd5462,
        17'd5042,  17'd4682,  17'd4370,  17'd4096
    };

    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [DC_W-1:0] divisor_count;
        logic            is_prime;
        logic [PT_W-1:0] prime_total;
        logic [ST_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic             mark;
        logic [DC_W-1:0]  dc;
        logic [EXP_W-1:0] ex;
        logic [LP_W-1:0]  lp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/lsdc_ram.sv @@
// generic single write port, single read port ram with registered read data
module lsdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lsdc_mult.sv @@
// shared multiplier with registered product
module lsdc_mult (
    input  logic                         clk,
    input  logic [lsdc_pkg::MUL_W-1:0]   a,
    input  logic [lsdc_pkg::MUL_W-1:0]   b,
    output logic [lsdc_pkg::PROD_W-1:0]  prod
);

    import lsdc_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/linear_sieve_divisor_count_top.sv @@
// top level of the linear sieve divisor count engine
// After reset the block runs a clearing pass over the whole table, TABLE_SIZE entries (65536),
// and takes no transaction on req until it ends; limit writes are taken at any time. A query
// that fails (table not built, index zero or above the built limit) is answered straight from
// the idle state; one that reads the table answers from S_QRD once the read data returns. A
// build visits each integer from 2 up to the limit and tries the stored primes against it in
// order, stopping when the product passes the limit or on the dividing prime, where the divisor
// count is rescaled. It is paced by the single table memory, read once and written once or more
// per integer, and by the one shared multiplier that forms i*p and the divisor count rescale.
module linear_sieve_divisor_count_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lsdc_pkg::VAL_W-1:0]    cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lsdc_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lsdc_pkg::rsp_t                rsp
);

    import lsdc_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_QRD   = 4'd2;
    localparam logic [3:0] S_BINIT = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BEV   = 4'd5;
    localparam logic [3:0] S_BPL   = 4'd6;
    localparam logic [3:0] S_BMUL  = 4'd7;
    localparam logic [3:0] S_BCHK  = 4'd8;
    localparam logic [3:0] S_BDIV  = 4'd9;
    localparam logic [3:0] S_BSCL  = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [VAL_W-1:0]    limit_reg;
    logic [VAL_W-1:0]    top_reg, top_next;
    logic [ITER_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [PT_W-1:0]     pcount_reg, pcount_next;
    logic                built_reg, built_next;
    logic [VAL_W-1:0]    blimit_reg, blimit_next;
    entry_t              cur_reg, cur_next;
    logic [TABLE_AW-1:0] m_reg, m_next;
    logic [TABLE_AW-1:0] clr_reg, clr_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                tab_we;
    logic [TABLE_AW-1:0] tab_waddr;
    entry_t              tab_wdata;
    logic [TABLE_AW-1:0] tab_raddr;
    logic [ENTRY_W-1:0]  tab_rdata;
    entry_t              tab_q;

    logic                pl_we;
    logic [PL_AW-1:0]    pl_waddr;
    logic [VAL_W-1:0]    pl_wdata;
    logic [PL_AW-1:0]    pl_raddr;
    logic [VAL_W-1:0]    pl_rdata;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;

    logic                req_fire;
    logic [VAL_W-1:0]    top_clip;
    logic [DC_W:0]       dc_dbl;
    logic [DC_W-1:0]     dc_twice;

    assign tab_q     = entry_t'(tab_rdata);
    assign req_fire  = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign top_clip  = (32'(limit_reg) > TABLE_MAX) ? VAL_W'(TABLE_MAX) : limit_reg;
    assign dc_dbl    = {cur_reg.dc, 1'b0};
    assign dc_twice  = dc_dbl[DC_W] ? DC_MAX : dc_dbl[DC_W-1:0];

    lsdc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    lsdc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PRIME_SLOTS)
    ) u_primes (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    lsdc_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        stored_next    = stored_reg;
        pcount_next    = pcount_reg;
        built_next     = built_reg;
        blimit_next    = blimit_reg;
        cur_next       = cur_reg;
        m_next         = m_reg;
        clr_next       = clr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        tab_we    = 1'b0;
        tab_waddr = '0;
        tab_wdata = '0;
        tab_raddr = '0;
        pl_we     = 1'b0;
        pl_waddr  = '0;
        pl_wdata  = '0;
        pl_raddr  = '0;
        mul_a     = '0;
        mul_b     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                tab_we    = 1'b1;
                tab_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_next.divisor_count = '0;
                    rsp_next.is_prime      = 1'b0;
                    rsp_next.prime_total   = pcount_reg;
                    if (req.func == FUNC_BUILD)
                    begin
                        top_next    = top_clip;
                        stored_next = '0;
                        pcount_next = '0;
                        state_next  = S_BINIT;
                    end
                    else if (!built_reg)
                    begin
                        rsp_next.status = ST_UNBUILT;
                        rsp_valid_next  = 1'b1;
                    end
                    else if (req.index == '0 || req.index > blimit_reg)
                    begin
                        rsp_next.status = ST_RANGE;
                        rsp_valid_next  = 1'b1;
                    end
                    else
                    begin
                        tab_raddr  = TABLE_AW'(req.index);
                        state_next = S_QRD;
                    end
                end
            end
            S_QRD:
            begin
                rsp_next.divisor_count = tab_q.dc;
                rsp_next.is_prime      = (tab_q.dc == DC_PRIME);
                rsp_next.prime_total   = pcount_reg;
                rsp_next.status        = ST_OK;
                rsp_valid_next         = 1'b1;
                state_next             = S_IDLE;
            end
            S_BINIT:
            begin
                if (top_reg != '0)
                begin
                    tab_we       = 1'b1;
                    tab_waddr    = TABLE_AW'(1);
                    tab_wdata.dc = DC_ONE;
                end
                i_next     = ITER_W'(2);
                state_next = S_BRD;
            end
            S_BRD:
            begin
                if (i_reg > {1'b0, top_reg})
                begin
                    built_next             = 1'b1;
                    blimit_next            = top_reg;
                    rsp_next.divisor_count = '0;
                    rsp_next.is_prime      = 1'b0;
                    rsp_next.prime_total   = pcount_reg;
                    rsp_next.status        = ST_OK;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    tab_raddr  = TABLE_AW'(i_reg);
                    state_next = S_BEV;
                end
            end
            S_BEV:
            begin
                if (!tab_q.mark)
                begin
                    cur_next.mark = 1'b0;
                    cur_next.dc   = DC_PRIME;
                    cur_next.ex   = EXP_PRIME;
                    cur_next.lp   = stored_reg;
                    if (stored_reg < CNT_W'(PRIME_SLOTS))
                    begin
                        pl_we       = 1'b1;
                        pl_waddr    = stored_reg[PL_AW-1:0];
                        pl_wdata    = i_reg[VAL_W-1:0];
                        stored_next = stored_reg + 1'b1;
                    end
                    pcount_next = (pcount_reg == PT_MAX) ? PT_MAX : pcount_reg + 1'b1;
                end
                else
                begin
                    cur_next      = tab_q;
                    cur_next.mark = 1'b0;
                end
                // rewrite with the mark cleared so the next build starts from a clean table
                tab_we     = 1'b1;
                tab_waddr  = TABLE_AW'(i_reg);
                tab_wdata  = cur_next;
                k_next     = '0;
                state_next = S_BPL;
            end
            S_BPL:
            begin
                if (k_reg >= stored_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_BRD;
                end
                else
                begin
                    pl_raddr   = k_reg[PL_AW-1:0];
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                mul_a      = MUL_W'(i_reg);
                mul_b      = MUL_W'(pl_rdata);
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (prod > PROD_W'(top_reg))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_BRD;
                end
                else
                begin
                    m_next = TABLE_AW'(prod);
                    if (k_reg == cur_reg.lp)
                    begin
                        mul_a      = MUL_W'(cur_reg.dc);
                        mul_b      = RECIP[cur_reg.ex];
                        state_next = S_BDIV;
                    end
                    else
                    begin
                        tab_we         = 1'b1;
                        tab_waddr      = TABLE_AW'(prod);
                        tab_wdata.mark = 1'b1;
                        tab_wdata.dc   = dc_twice;
                        tab_wdata.ex   = EXP_PRIME;
                        tab_wdata.lp   = k_reg;
                        k_next         = k_reg + 1'b1;
                        state_next     = S_BPL;
                    end
                end
            end
            S_BDIV:
            begin
                mul_a      = MUL_W'(prod[RECIP_SHIFT +: DC_W]);
                mul_b      = MUL_W'(cur_reg.ex) + MUL_W'(2);
                state_next = S_BSCL;
            end
            S_BSCL:
            begin
                tab_we         = 1'b1;
                tab_waddr      = m_reg;
                tab_wdata.mark = 1'b1;
                tab_wdata.dc   = (prod > PROD_W'(DC_MAX)) ? DC_MAX : prod[DC_W-1:0];
                tab_wdata.ex   = (cur_reg.ex == EXP_MAX) ? EXP_MAX : cur_reg.ex + 1'b1;
                tab_wdata.lp   = k_reg;
                i_next         = i_reg + 1'b1;
                state_next     = S_BRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_reg     <= 16'hFFFF;
            clr_reg       <= '0;
            stored_reg    <= '0;
            pcount_reg    <= '0;
            built_reg     <= 1'b0;
            blimit_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            stored_reg    <= stored_next;
            pcount_reg    <= pcount_next;
            built_reg     <= built_next;
            blimit_reg    <= blimit_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        i_reg   <= i_next;
        k_reg   <= k_next;
        cur_reg <= cur_next;
        m_reg   <= m_next;
        rsp_reg <= rsp_next;
    end

    a_qrd_answers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QRD |=> rsp_valid_reg)
        else $error("table lookup did not produce a transaction");

    a_chk_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BCHK |-> k_reg < stored_reg)
        else $error("prime slot beyond stored primes");

    a_built_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> rsp_valid_reg && rsp_reg.status == ST_OK)
        else $error("build finished without its result");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !rsp_valid_reg && !req_ready)
        else $error("activity during clearing pass");

endmodule
